### sv/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants of the expression syntax checker: status codes,
// character codes and the result record handed from the core to the top level.
// ----------------------------------------------------------------------------
package esc_pkg;

   localparam int MAX_LEN_DEF = 4096;
   localparam int POS_W       = 13;
   localparam int CH_W        = 8;

   localparam logic [POS_W-1:0] DEPTH_MAX = {POS_W{1'b1}};

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_VALID   = 3'd1,
      ST_BADEXPR = 3'd2,
      ST_PAREN   = 3'd3,
      ST_BADCHAR = 3'd4,
      ST_IGNORED = 3'd5
   } status_type;

   localparam logic [CH_W-1:0] CH_POINT  = 8'h2E;
   localparam logic [CH_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [CH_W-1:0] CH_SLASH  = 8'h2F;
   localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
   localparam logic [CH_W-1:0] CH_CARET  = 8'h5E;
   localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
   localparam logic [CH_W-1:0] CH_PCT    = 8'h25;
   localparam logic [CH_W-1:0] CH_OPEN   = 8'h28;
   localparam logic [CH_W-1:0] CH_CLOSE  = 8'h29;
   localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
   localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
   localparam logic [CH_W-1:0] CH_CR     = 8'h0D;

   typedef struct packed {
      status_type       status;
      logic [POS_W-1:0] err_start;
      logic [POS_W-1:0] err_end;
   } result_type;

   // space, tab, lf, vt, ff, cr
   function automatic logic is_space(input logic [CH_W-1:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

endpackage

### sv/esc_core.sv
// ----------------------------------------------------------------------------
// esc_core
// Checker state and the per-character decision logic. One character is
// consumed in each cycle that advance is high; the result is combinational.
// ----------------------------------------------------------------------------
module esc_core #(
   parameter int MAX_LEN = esc_pkg::MAX_LEN_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic [esc_pkg::CH_W-1:0] ch,
   input  logic                    last,
   output esc_pkg::result_type     result
);
   import esc_pkg::*;

   localparam int PW = $clog2(MAX_LEN);
   localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_LEN - 1);

   logic [CH_W-1:0]  prev_sig_ff, prev_sig_in;
   logic             prev_sig_vld_ff, prev_sig_vld_in;
   logic [CH_W-1:0]  raw_prev_ff, raw_prev_in;
   logic             raw_prev_vld_ff, raw_prev_vld_in;
   logic             point_seen_ff, point_seen_in;
   logic             doubled_op_ff, doubled_op_in;
   logic [POS_W-1:0] depth_ff, depth_in;
   logic [POS_W-1:0] first_open_ff, first_open_in;
   logic [PW-1:0]    pos_ff, pos_in;
   logic             err_ff, err_in;

   logic [PW+POS_W-1:0] pos_ext;
   logic [POS_W-1:0]    pos13;
   status_type          st;
   logic [POS_W-1:0]    es, ee;

   // reported positions wrap at the width of the output fields
   assign pos_ext = {{POS_W{1'b0}}, pos_ff};
   assign pos13   = pos_ext[POS_W-1:0];

   always_comb begin
      prev_sig_in     = prev_sig_ff;
      prev_sig_vld_in = prev_sig_vld_ff;
      point_seen_in   = point_seen_ff;
      doubled_op_in   = doubled_op_ff;
      depth_in        = depth_ff;
      first_open_in   = first_open_ff;
      st              = ST_OK;
      es              = '0;
      ee              = '0;

      if (err_ff) begin
         st = ST_IGNORED;
      end else if (ch inside {[CH_ZERO:CH_NINE]}) begin
         prev_sig_in     = ch;
         prev_sig_vld_in = 1'b1;
      end else if (is_space(ch)) begin
         st = ST_OK;
      end else if (prev_sig_vld_ff && prev_sig_ff == CH_POINT) begin
         // point not followed by a digit
         st = ST_BADEXPR;
         es = pos13 - POS_W'(1);
         ee = pos13;
      end else if (ch == CH_POINT) begin
         if (point_seen_ff) begin
            st = ST_BADEXPR;
            es = pos13;
            ee = pos13 + POS_W'(1);
         end else begin
            point_seen_in   = 1'b1;
            prev_sig_in     = ch;
            prev_sig_vld_in = 1'b1;
         end
      end else if (ch == CH_STAR || ch == CH_SLASH) begin
         if (raw_prev_vld_ff && raw_prev_ff == ch) begin
            if (doubled_op_ff) begin
               st = ST_BADEXPR;
               es = pos13;
               ee = pos13 + POS_W'(1);
            end else begin
               doubled_op_in = 1'b1;
            end
         end else begin
            doubled_op_in = 1'b0;
         end
         if (st == ST_OK) begin
            prev_sig_in     = ch;
            prev_sig_vld_in = 1'b1;
            point_seen_in   = 1'b0;
         end
      end else begin
         if (ch inside {CH_PLUS, CH_CARET, CH_MINUS, CH_PCT}) begin
            if (prev_sig_vld_ff && prev_sig_ff == ch) begin
               st = ST_BADEXPR;
               es = pos13 - POS_W'(1);
               ee = pos13 + POS_W'(1);
            end
         end else if (ch == CH_OPEN) begin
            if (depth_ff == '0) begin
               first_open_in = pos13;
            end
            if (depth_ff < DEPTH_MAX) begin
               depth_in = depth_ff + POS_W'(1);
            end
         end else if (ch == CH_CLOSE) begin
            if (depth_ff == '0) begin
               st = ST_PAREN;
               es = pos13;
               ee = pos13 + POS_W'(1);
            end else begin
               depth_in = depth_ff - POS_W'(1);
               if (depth_in == '0) begin
                  first_open_in = '0;
               end
            end
         end else begin
            st = ST_BADCHAR;
            es = pos13;
            ee = pos13 + POS_W'(1);
         end
         if (st == ST_OK) begin
            prev_sig_in     = ch;
            prev_sig_vld_in = 1'b1;
            point_seen_in   = 1'b0;
         end
      end

      err_in          = err_ff || (st != ST_OK && st != ST_IGNORED);
      raw_prev_in     = ch;
      raw_prev_vld_in = 1'b1;
      pos_in          = (pos_ff < POS_LIMIT) ? pos_ff + PW'(1) : pos_ff;

      if (last) begin
         if (st == ST_OK) begin
            if (depth_in != '0) begin
               st = ST_PAREN;
               es = first_open_in;
               ee = first_open_in + POS_W'(1);
            end else begin
               st = ST_VALID;
            end
         end
         prev_sig_vld_in = 1'b0;
         raw_prev_vld_in = 1'b0;
         point_seen_in   = 1'b0;
         doubled_op_in   = 1'b0;
         depth_in        = '0;
         first_open_in   = '0;
         pos_in          = '0;
         err_in          = 1'b0;
      end
   end

   assign result = '{status: st, err_start: es, err_end: ee};

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_sig_vld_ff <= 1'b0;
         raw_prev_vld_ff <= 1'b0;
         point_seen_ff   <= 1'b0;
         doubled_op_ff   <= 1'b0;
         depth_ff        <= '0;
         first_open_ff   <= '0;
         pos_ff          <= '0;
         err_ff          <= 1'b0;
      end else if (advance) begin
         prev_sig_vld_ff <= prev_sig_vld_in;
         raw_prev_vld_ff <= raw_prev_vld_in;
         point_seen_ff   <= point_seen_in;
         doubled_op_ff   <= doubled_op_in;
         depth_ff        <= depth_in;
         first_open_ff   <= first_open_in;
         pos_ff          <= pos_in;
         err_ff          <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prev_sig_ff <= prev_sig_in;
         raw_prev_ff <= raw_prev_in;
      end
   end

endmodule

### sv/expression_syntax_checker_top.sv
// ----------------------------------------------------------------------------
// expression_syntax_checker_top
// Streaming syntax checker for arithmetic expressions, one byte per transaction.
// ----------------------------------------------------------------------------
// Each request transaction carries one expression character and a last flag;
// each one yields exactly one response transaction with a status and an error
// span. Throughput is one character per clock while the response channel does
// not stall: a character is held in an input register, the checker state and
// the response are computed in a single pass of shallow logic, and the response
// lands in an output register, so each response passes through the input register
// and then the output register before it is presented. The pair of registers
// lets a new request be taken while a finished response waits under stall.
// The first error of an expression is reported with its span; later
// characters answer ignored until the last flag, after which all state clears.
// Positions saturate at MAX_LEN-1 and are reported modulo 8192.
module expression_syntax_checker_top #(
   parameter int MAX_LEN = esc_pkg::MAX_LEN_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [esc_pkg::CH_W-1:0]  req_ch,
   input  logic                      req_last,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [2:0]                rsp_status,
   output logic [esc_pkg::POS_W-1:0] rsp_err_start,
   output logic [esc_pkg::POS_W-1:0] rsp_err_end
);
   import esc_pkg::*;

   // input register
   logic            in_valid_ff, in_valid_in;
   logic [CH_W-1:0] in_ch_ff;
   logic            in_last_ff;

   // output register
   logic            out_valid_ff, out_valid_in;
   result_type      out_res_ff;

   logic            out_free;   // output register can take a result this cycle
   logic            advance;    // held character moves through the checker
   logic            req_take;   // request transaction completes
   result_type      core_res;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // input register refills in the same cycle it drains
   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // output register holds until the response transaction completes
   always_comb begin
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ch_ff   <= req_ch;
         in_last_ff <= req_last;
      end
      if (advance) begin
         out_res_ff <= core_res;
      end
   end

   // per-character decision logic and checker state
   esc_core #(
      .MAX_LEN (MAX_LEN)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .ch      (in_ch_ff),
      .last    (in_last_ff),
      .result  (core_res)
   );

   assign rsp_valid     = out_valid_ff;
   assign rsp_status    = out_res_ff.status;
   assign rsp_err_start = out_res_ff.err_start;
   assign rsp_err_end   = out_res_ff.err_end;

`ifndef ASSERT_OFF
   // non-error statuses never carry a span
   a_no_span: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_OK || rsp_status == ST_VALID ||
                     rsp_status == ST_IGNORED))
      |-> (rsp_err_start == '0 && rsp_err_end == '0))
      else $error("span reported without an error");

   // requests are only held back by a stalled, full output register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled while output could drain");

   // a held character always moves on when the output side is free
   a_advance: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !rsp_valid) |=> rsp_valid)
      else $error("held character did not reach the output register");

   // nothing is presented straight after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");
`endif

endmodule
